// File: hw/rtl/slc_pkg.sv
// shared types and constants for the sparse linear classifier
package slc_pkg;

    // class lanes, fixed by the 3-bit class fields
    localparam int unsigned NUM_LANES   = 8;
    localparam int unsigned LANE_W      = 3;
    localparam int unsigned FEAT_W      = 10;
    localparam int unsigned WEIGHT_W    = 16;
    localparam int unsigned PROD_W      = 32;
    localparam int unsigned SCORE_W     = 40;
    localparam int unsigned NCLS_W      = 4;
    // wide enough to hold any feature count
    localparam int unsigned FEAT_CMP_W  = 17;

    // item mode codes
    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_TERM   = 1'b1;

    localparam logic [NCLS_W-1:0] NCLS_RESET = 4'd8;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // input word
    typedef struct packed {
        logic                       mode;
        logic [FEAT_W-1:0]          feat_index;
        logic [LANE_W-1:0]          class_index;
        logic signed [WEIGHT_W-1:0] weight_value;
        logic signed [WEIGHT_W-1:0] term_value;
        logic                       last_term;
    } item_t;

    // result word
    typedef struct packed {
        logic [LANE_W-1:0]         top_class;
        logic signed [SCORE_W-1:0] best_score;
    } result_t;

    // argmax candidate
    typedef struct packed {
        logic                      live;
        logic [LANE_W-1:0]         idx;
        logic signed [SCORE_W-1:0] score;
    } cand_t;

endpackage

// File: hw/rtl/sparse_linear_classifier.sv
// sparse linear classifier: weight table, per-class score lanes and argmax
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+------------------------
//  item     | in        | item_valid/item_stall | slc_pkg::item_t
//  result   | out       | result_valid/result_stall | slc_pkg::result_t
//  cfg      | in        | cfg_wr_en             | num_classes (4 bits)
//
// One word can be taken every cycle while item_stall is low. The accepting edge
// also registers the weight row (all eight classes) from eight lane memories;
// products, score update, a first argmax level and the output register follow, and
// result_valid rises once a last term has passed through all of them.
// Reset clears scores and control at once; the weight memory has no reset.
// item_stall rises only while a finished result waits in the argmax stage and the
// result word is held by result_stall; then the whole pipe freezes.
module sparse_linear_classifier #(
    parameter int unsigned NUM_FEATURES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  slc_pkg::item_t                item_word,
    output logic                          result_valid,
    input  logic                          result_stall,
    output slc_pkg::result_t              result_word,
    input  logic                          cfg_wr_en,
    input  logic [slc_pkg::NCLS_W-1:0]    cfg_wr_data
);

    localparam int unsigned ADDR_W = $clog2(NUM_FEATURES);
    localparam int unsigned NL     = slc_pkg::NUM_LANES;

    // pipe control
    logic                   pipe_en;
    logic                   item_accept;
    logic [slc_pkg::FEAT_CMP_W-1:0] feat_ext;
    logic                   feat_hit;
    logic [ADDR_W-1:0]      feat_addr;

    // stage 1: weight row read
    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic                   s1_hit_reg;
    logic signed [slc_pkg::WEIGHT_W-1:0] s1_fval_reg;
    logic signed [slc_pkg::WEIGHT_W-1:0] rdata_reg [NL];

    // stage 2: products
    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    logic signed [slc_pkg::PROD_W-1:0]   prod_reg [NL];

    // scores
    logic signed [slc_pkg::SCORE_W-1:0]  score_reg  [NL];
    logic signed [slc_pkg::SCORE_W-1:0]  score_next [NL];

    // stage 3: final scores of a sample
    logic                   s3_valid_reg;
    logic signed [slc_pkg::SCORE_W-1:0]  fin_reg [NL];
    logic [NL-1:0]          lane_live;

    // stage 4: half-reduced argmax
    logic                   s4_valid_reg;
    slc_pkg::cand_t         s4_cand_reg [NL/2];
    slc_pkg::cand_t         s4_left;
    slc_pkg::cand_t         s4_right;
    slc_pkg::cand_t         s4_best;

    // output register
    logic                   out_valid_reg;
    slc_pkg::result_t       out_word_reg;

    // configuration
    logic [slc_pkg::NCLS_W-1:0] num_classes_reg;

    // keep a over b unless b is live and either a is not live or b is strictly larger
    function automatic slc_pkg::cand_t pick(input slc_pkg::cand_t a, input slc_pkg::cand_t b);
        slc_pkg::cand_t r;
        r = a;
        if (b.live && (!a.live || (b.score > a.score)))
        begin
            r = b;
        end
        return r;
    endfunction

    // freeze only when a result cannot move into the held output word
    assign pipe_en     = !(s4_valid_reg && out_valid_reg && result_stall);
    assign item_stall  = !pipe_en;
    assign item_accept = item_valid && pipe_en;

    // feature range check and row address
    assign feat_ext  = {{(slc_pkg::FEAT_CMP_W - slc_pkg::FEAT_W){1'b0}}, item_word.feat_index};
    assign feat_hit  = feat_ext < slc_pkg::FEAT_CMP_W'(NUM_FEATURES);
    assign feat_addr = feat_ext[ADDR_W-1:0];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= slc_pkg::NCLS_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_classes_reg <= cfg_wr_data;
        end
    end

    // one weight memory per class lane
    for (genvar j = 0; j < NL; j++)
    begin : g_lane_mem
        logic [slc_pkg::WEIGHT_W-1:0] wmem [NUM_FEATURES];

        always_ff @(posedge clk)
        begin
            if (item_accept && (item_word.mode == slc_pkg::MODE_WEIGHT) && feat_hit
                && (item_word.class_index == slc_pkg::LANE_W'(j)))
            begin
                wmem[feat_addr] <= item_word.weight_value;
            end
            if (pipe_en)
            begin
                rdata_reg[j] <= $signed(wmem[feat_addr]);
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= item_accept && (item_word.mode == slc_pkg::MODE_TERM);
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_last_reg <= item_word.last_term;
            s1_hit_reg  <= feat_hit;
            s1_fval_reg <= item_word.term_value;
        end
    end

    // stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 2 signed products, zero for a feature outside the table
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_last_reg <= s1_last_reg;
            for (int j = 0; j < NL; j++)
            begin
                prod_reg[j] <= s1_hit_reg ? slc_pkg::PROD_W'(rdata_reg[j] * s1_fval_reg)
                                          : slc_pkg::PROD_W'(0);
            end
        end
    end

    // saturating score update
    always_comb
    begin
        logic signed [slc_pkg::SCORE_W:0] sum;
        for (int j = 0; j < NL; j++)
        begin
            sum = {score_reg[j][slc_pkg::SCORE_W-1], score_reg[j]}
                + (slc_pkg::SCORE_W+1)'(prod_reg[j]);
            if (sum[slc_pkg::SCORE_W] != sum[slc_pkg::SCORE_W-1])
            begin
                score_next[j] = sum[slc_pkg::SCORE_W] ? slc_pkg::SCORE_MIN : slc_pkg::SCORE_MAX;
            end
            else
            begin
                score_next[j] = sum[slc_pkg::SCORE_W-1:0];
            end
        end
    end

    // score registers, cleared after the last term of a sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NL; j++)
            begin
                score_reg[j] <= '0;
            end
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
            begin
                for (int j = 0; j < NL; j++)
                begin
                    score_reg[j] <= s2_last_reg ? '0 : score_next[j];
                end
            end
        end
    end

    // stage 3 final scores
    always_ff @(posedge clk)
    begin
        if (pipe_en && s2_valid_reg && s2_last_reg)
        begin
            for (int j = 0; j < NL; j++)
            begin
                fin_reg[j] <= score_next[j];
            end
        end
    end

    // lanes in the argmax: lane 0 always, others below the class count
    always_comb
    begin
        for (int j = 0; j < NL; j++)
        begin
            lane_live[j] = (j == 0) || (slc_pkg::NCLS_W'(j) < num_classes_reg);
        end
    end

    // stage 4 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // first argmax level, pairs of lanes
    always_ff @(posedge clk)
    begin
        slc_pkg::cand_t ca;
        slc_pkg::cand_t cb;
        if (pipe_en)
        begin
            for (int k = 0; k < NL/2; k++)
            begin
                ca.live  = lane_live[2*k];
                ca.idx   = slc_pkg::LANE_W'(2*k);
                ca.score = fin_reg[2*k];
                cb.live  = lane_live[2*k+1];
                cb.idx   = slc_pkg::LANE_W'(2*k+1);
                cb.score = fin_reg[2*k+1];
                s4_cand_reg[k] <= pick(ca, cb);
            end
        end
    end

    // remaining argmax levels
    assign s4_left  = pick(s4_cand_reg[0], s4_cand_reg[1]);
    assign s4_right = pick(s4_cand_reg[2], s4_cand_reg[3]);
    assign s4_best  = pick(s4_left, s4_right);

    // output word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s4_valid_reg && pipe_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && pipe_en)
        begin
            out_word_reg.top_class  <= s4_best.idx;
            out_word_reg.best_score <= s4_best.score;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

// File: hw/rtl/slc_checker.sv
// port-level checks for the sparse linear classifier
module slc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_stall,
    input logic                       result_valid,
    input logic                       result_stall,
    input slc_pkg::result_t           result_word
);

    // a held result word stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stall without a held result");

    // reset leaves no result and no backpressure
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !item_stall)
        else $error("activity during reset");

endmodule

bind sparse_linear_classifier slc_checker u_slc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);

// File: tb/sparse_linear_classifier_test.sv
// self-checking testbench for the sparse linear classifier: weight loads, scored samples, argmax
`timescale 1ns / 1ps

module sparse_linear_classifier_test;

    localparam int unsigned FEAT_COUNT   = 1024;
    localparam int unsigned SAT_TERMS    = 516;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned SETTLE_WAIT  = 10;
    localparam logic [slc_pkg::FEAT_W-1:0] SAT_FEAT = 10'd1023;
    localparam logic [slc_pkg::FEAT_W-1:0] BIAS_FEAT = 10'd0;
    localparam logic [slc_pkg::WEIGHT_W-1:0] Q_ONE = 16'h0100;
    localparam logic [slc_pkg::WEIGHT_W-1:0] Q_MAX = 16'h7fff;
    localparam logic [slc_pkg::WEIGHT_W-1:0] Q_MIN = 16'h8000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    slc_pkg::item_t     item_word    = '0;
    logic               result_valid;
    logic               result_stall = 1'b1;
    slc_pkg::result_t   result_word;
    logic               cfg_wr_en    = 1'b0;
    logic [slc_pkg::NCLS_W-1:0] cfg_wr_data = '0;

    // stimulus side
    slc_pkg::item_t pending_words[$];
    int unsigned    items_queued = 0;
    int unsigned    items_sent   = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    bit             hold_sender  = 1'b0;
    bit             word_taken   = 1'b0;
    bit [slc_pkg::NUM_LANES-1:0] row_loaded [FEAT_COUNT];
    int unsigned    full_rows[$];

    // predicted block state
    logic signed [slc_pkg::WEIGHT_W-1:0] class_weight [FEAT_COUNT][slc_pkg::NUM_LANES];
    logic signed [slc_pkg::SCORE_W-1:0]  class_score [slc_pkg::NUM_LANES];
    logic [slc_pkg::NCLS_W-1:0]          class_count_model = slc_pkg::NCLS_RESET;
    slc_pkg::result_t                    expected_results[$];
    int unsigned                         errors = 0;

    sparse_linear_classifier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_word    (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // predicted effect of one accepted word
    task automatic classify_word(input slc_pkg::item_t w);
        logic signed [47:0] acc;
        int unsigned        used;
        int unsigned        best_idx;
        slc_pkg::result_t   res;
        if (w.mode == slc_pkg::MODE_WEIGHT)
        begin
            class_weight[w.feat_index][w.class_index] = w.weight_value;
            return;
        end
        for (int j = 0; j < slc_pkg::NUM_LANES; j++)
        begin
            acc = $signed(class_score[j])
                + $signed(class_weight[w.feat_index][j]) * $signed(w.term_value);
            if (acc > slc_pkg::SCORE_MAX)
                acc = slc_pkg::SCORE_MAX;
            else if (acc < slc_pkg::SCORE_MIN)
                acc = slc_pkg::SCORE_MIN;
            class_score[j] = acc[slc_pkg::SCORE_W-1:0];
        end
        if (!w.last_term)
            return;
        // class count of zero means one, anything past the lanes means all
        used = class_count_model;
        if (used == 0)
            used = 1;
        if (used > slc_pkg::NUM_LANES)
            used = slc_pkg::NUM_LANES;
        best_idx = 0;
        for (int j = 1; j < used; j++)
        begin
            if (class_score[j] > class_score[best_idx])
                best_idx = j;
        end
        res.top_class  = slc_pkg::LANE_W'(best_idx);
        res.best_score = class_score[best_idx];
        expected_results.insert(expected_results.size(), res);
        for (int j = 0; j < slc_pkg::NUM_LANES; j++)
            class_score[j] = '0;
    endtask

    // monitor: accepted words, register writes and result checks at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: class %0d score %0d", $time,
                             result_word.top_class, result_word.best_score);
                end
                else
                begin
                    if (result_word.top_class !== expected_results[0].top_class
                        || result_word.best_score !== expected_results[0].best_score)
                    begin
                        errors++;
                        $display("%0t: result mismatch: expected class %0d score %0d, %s %0d %s %0d",
                                 $time, expected_results[0].top_class,
                                 expected_results[0].best_score,
                                 "got class", result_word.top_class,
                                 "score", result_word.best_score);
                    end
                    void'(expected_results.pop_front());
                end
            end
            word_taken = item_valid && !item_stall;
            if (word_taken)
            begin
                classify_word(item_word);
                items_sent++;
            end
            if (cfg_wr_en)
                class_count_model = cfg_wr_data;
        end
    end

    // driver: next word after acceptance, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || word_taken))
        begin
            if (!hold_sender && pending_words.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                item_word  <= pending_words.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result receiver stalls at random
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // q8.8 value biased toward the extremes
    function automatic logic [slc_pkg::WEIGHT_W-1:0] pick_q88();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            default: return slc_pkg::WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic slc_pkg::item_t weight_word(input logic [slc_pkg::FEAT_W-1:0] feat,
                                                   input logic [slc_pkg::LANE_W-1:0] cls,
                                                   input logic [slc_pkg::WEIGHT_W-1:0] val,
                                                   input logic last);
        slc_pkg::item_t w;
        w.mode         = slc_pkg::MODE_WEIGHT;
        w.feat_index   = feat;
        w.class_index  = cls;
        w.weight_value = val;
        w.term_value   = slc_pkg::WEIGHT_W'($urandom);
        w.last_term    = last;
        return w;
    endfunction

    function automatic slc_pkg::item_t term_word(input logic [slc_pkg::FEAT_W-1:0] feat,
                                                 input logic [slc_pkg::WEIGHT_W-1:0] val,
                                                 input logic last);
        slc_pkg::item_t w;
        w.mode         = slc_pkg::MODE_TERM;
        w.feat_index   = feat;
        w.class_index  = slc_pkg::LANE_W'($urandom);
        w.weight_value = slc_pkg::WEIGHT_W'($urandom);
        w.term_value   = val;
        w.last_term    = last;
        return w;
    endfunction

    // queue a word and track which weight rows are completely loaded
    task automatic queue_word(input slc_pkg::item_t w);
        bit was_full;
        if (w.mode == slc_pkg::MODE_WEIGHT)
        begin
            was_full = &row_loaded[w.feat_index];
            row_loaded[w.feat_index][w.class_index] = 1'b1;
            if (!was_full && &row_loaded[w.feat_index])
                full_rows.insert(full_rows.size(), 32'(w.feat_index));
        end
        pending_words.insert(pending_words.size(), w);
        items_queued++;
    endtask

    task automatic load_row(input logic [slc_pkg::FEAT_W-1:0] feat);
        for (int c = 0; c < slc_pkg::NUM_LANES; c++)
            queue_word(weight_word(feat, slc_pkg::LANE_W'(c), pick_q88(),
                                   1'($urandom_range(1))));
    endtask

    // long sample on the extreme row, drives scores into both clamps
    task automatic queue_saturation();
        for (int t = 0; t < SAT_TERMS; t++)
            queue_word(term_word(SAT_FEAT, Q_MIN, t == SAT_TERMS - 1));
    endtask

    // mostly well-formed samples over loaded rows, plus row loads and stray writes
    task automatic queue_random(input int unsigned count);
        int unsigned    start;
        int unsigned    nterms;
        int unsigned    feat;
        start = items_queued;
        while (items_queued - start < count)
        begin
            case ($urandom_range(19))
                0, 1, 2: load_row(slc_pkg::FEAT_W'($urandom_range(FEAT_COUNT - 2)));
                3: queue_word(weight_word(slc_pkg::FEAT_W'($urandom_range(FEAT_COUNT - 2)),
                                          slc_pkg::LANE_W'($urandom), pick_q88(),
                                          1'($urandom_range(1))));
                default:
                begin
                    nterms = ($urandom_range(7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                    for (int t = 0; t < nterms; t++)
                    begin
                        // rewrite a weight of a loaded row in the middle of a sample
                        if ($urandom_range(9) == 0)
                        begin
                            feat = full_rows[$urandom_range(full_rows.size() - 1)];
                            if (feat != SAT_FEAT)
                                queue_word(weight_word(slc_pkg::FEAT_W'(feat),
                                                       slc_pkg::LANE_W'($urandom),
                                                       pick_q88(),
                                                       1'($urandom_range(1))));
                        end
                        feat = full_rows[$urandom_range(full_rows.size() - 1)];
                        queue_word(term_word(slc_pkg::FEAT_W'(feat), pick_q88(),
                                             t == nterms - 1));
                    end
                end
            endcase
        end
    endtask

    // once the words up to the mark are sent, hold the sender until every result is back
    task automatic pause_sender(input int unsigned mark);
        while (items_sent < mark)
            @(negedge clk);
        hold_sender = 1'b1;
        do
            @(negedge clk);
        while (item_valid || expected_results.size() != 0);
        hold_sender = 1'b0;
    endtask

    // everything accepted, all results back, pipe settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_sent != items_queued || expected_results.size() != 0);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_class_count(input logic [slc_pkg::NCLS_W-1:0] value);
        @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        logic [slc_pkg::NCLS_W-1:0] setting;
        int unsigned                pause_mark;
        for (int f = 0; f < FEAT_COUNT; f++)
            row_loaded[f] = '0;
        for (int j = 0; j < slc_pkg::NUM_LANES; j++)
            class_score[j] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 6; phase++)
        begin
            // sender light and receiver heavy, then swapped, then none
            if (phase < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 80;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                1: setting = 4'd1;
                2: setting = 4'd0;
                3: setting = 4'd15;
                4: setting = slc_pkg::NCLS_W'($urandom_range(2, 7));
                default: setting = 4'd8;
            endcase
            if (phase != 0)
                write_class_count(setting);

            if (phase == 0)
            begin
                // bias row with extreme weights; one write carries a stray last mark
                queue_word(weight_word(BIAS_FEAT, 0, Q_ONE, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 1, 16'hffff, 1'b1));
                queue_word(weight_word(BIAS_FEAT, 2, Q_MAX, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 3, Q_MIN, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 4, 16'h0000, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 5, 16'h0001, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 6, 16'h0080, 1'b0));
                queue_word(weight_word(BIAS_FEAT, 7, 16'hff00, 1'b0));
                // top feature row used for the clamp runs
                queue_word(weight_word(SAT_FEAT, 0, Q_MAX, 1'b0));
                queue_word(weight_word(SAT_FEAT, 1, Q_MIN, 1'b0));
                queue_word(weight_word(SAT_FEAT, 2, Q_MIN, 1'b0));
                queue_word(weight_word(SAT_FEAT, 3, 16'h0000, 1'b0));
                queue_word(weight_word(SAT_FEAT, 4, Q_MAX, 1'b0));
                queue_word(weight_word(SAT_FEAT, 5, Q_MIN, 1'b0));
                queue_word(weight_word(SAT_FEAT, 6, 16'h0001, 1'b0));
                queue_word(weight_word(SAT_FEAT, 7, 16'hffff, 1'b1));
                // bias alone
                queue_word(term_word(BIAS_FEAT, Q_ONE, 1'b1));
                // bias plus most negative value
                queue_word(term_word(BIAS_FEAT, Q_ONE, 1'b0));
                queue_word(term_word(SAT_FEAT, Q_MIN, 1'b1));
                // largest value then most negative bias
                queue_word(term_word(SAT_FEAT, Q_MAX, 1'b0));
                queue_word(term_word(BIAS_FEAT, Q_MIN, 1'b1));
                // all scores zero, tie goes to class zero
                queue_word(term_word(BIAS_FEAT, 16'h0000, 1'b1));
            end
            // clamp runs: positive clamp with a three-way tie, then negative clamp alone
            if (phase < 2)
                queue_saturation();

            queue_random(PHASE_ITEMS / 2);
            pause_mark = items_queued;
            queue_random(PHASE_ITEMS / 2);
            pause_sender(pause_mark);
            wait_idle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sparse_linear_classifier.f
hw/rtl/slc_pkg.sv
hw/rtl/sparse_linear_classifier.sv
hw/rtl/slc_checker.sv
tb/sparse_linear_classifier_test.sv
